[rtl/json_string_unescape_utf8_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the JSON string unescaper
// Concurrent-assertion forms used by the jsu_back RTL module.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jsu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jsu: next-cycle check failed");

`endif

[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int CpWidth      = 21;
   localparam int HexWidth     = 16;
   localparam int FifoDepth    = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = FifoPtrWidth + 1;

   // Characters that the escape decoder recognizes.
   localparam logic [CpWidth-1:0] CharBackslash = 21'h00005C;
   localparam logic [CpWidth-1:0] CharQuote     = 21'h000022;
   localparam logic [CpWidth-1:0] CharSlash     = 21'h00002F;
   localparam logic [CpWidth-1:0] CharLowerB    = 21'h000062;
   localparam logic [CpWidth-1:0] CharLowerF    = 21'h000066;
   localparam logic [CpWidth-1:0] CharLowerN    = 21'h00006E;
   localparam logic [CpWidth-1:0] CharLowerR    = 21'h000072;
   localparam logic [CpWidth-1:0] CharLowerT    = 21'h000074;
   localparam logic [CpWidth-1:0] CharLowerU    = 21'h000075;
   localparam logic [CpWidth-1:0] CharDigit0    = 21'h000030;
   localparam logic [CpWidth-1:0] CharDigit9    = 21'h000039;
   localparam logic [CpWidth-1:0] CharLowerA    = 21'h000061;
   localparam logic [CpWidth-1:0] CharUpperA    = 21'h000041;
   localparam logic [CpWidth-1:0] CharUpperF    = 21'h000046;

   // Control characters produced by the short escapes.
   localparam logic [6:0] CtlBackspace = 7'h08;
   localparam logic [6:0] CtlFormFeed  = 7'h0C;
   localparam logic [6:0] CtlNewline   = 7'h0A;
   localparam logic [6:0] CtlReturn    = 7'h0D;
   localparam logic [6:0] CtlTab       = 7'h09;

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] Utf8Cont  = 8'h80;
   localparam logic [7:0] Utf8Lead2 = 8'hC0;
   localparam logic [7:0] Utf8Lead3 = 8'hE0;
   localparam logic [7:0] Utf8Lead4 = 8'hF0;

   // Escape decoder state.
   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_ESCAPE,
      MODE_HEX4,
      MODE_HEX3,
      MODE_HEX2,
      MODE_HEX1,
      MODE_DISCARD
   } mode_type;

   // Byte count of an encoded code point, minus one.
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_type;

   // One queued command: either a code point to encode or a single
   // control result (error or token close) without a byte.
   typedef struct packed {
      logic               is_ctrl;
      logic               err;
      logic               last;
      len_type            len_m1;
      logic [CpWidth-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] val;
   } esc_type;

   // Value of an ASCII hex digit, with a flag for a valid digit.
   function automatic hex_type hex_digit(input logic [CpWidth-1:0] cp);
      hex_type r;
      r.ok  = 1'b1;
      r.val = cp[3:0];
      if (cp >= CharDigit0 && cp <= CharDigit9) begin
         r.val = cp[3:0];
      end else if ((cp >= CharLowerA && cp <= CharLowerF) ||
                   (cp >= CharUpperA && cp <= CharUpperF)) begin
         r.val = cp[3:0] + 4'd9;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // Character produced by a one-letter escape.
   function automatic esc_type escape_map(input logic [CpWidth-1:0] cp);
      esc_type r;
      r.ok  = 1'b1;
      r.val = cp[6:0];
      unique case (cp)
         CharQuote, CharBackslash, CharSlash: r.val = cp[6:0];
         CharLowerB: r.val = CtlBackspace;
         CharLowerF: r.val = CtlFormFeed;
         CharLowerN: r.val = CtlNewline;
         CharLowerR: r.val = CtlReturn;
         CharLowerT: r.val = CtlTab;
         default:    r.ok  = 1'b0;
      endcase
      return r;
   endfunction

   // Number of UTF-8 bytes of a code point, minus one.
   function automatic len_type utf8_len(input logic [CpWidth-1:0] cp);
      len_type r;
      if (cp[20:7] == '0) begin
         r = LEN_ONE;
      end else if (cp[20:11] == '0) begin
         r = LEN_TWO;
      end else if (cp[20:16] == '0) begin
         r = LEN_THREE;
      end else begin
         r = LEN_FOUR;
      end
      return r;
   endfunction

   // Byte at position idx of the UTF-8 encoding of cp.
   function automatic logic [7:0] utf8_byte(input logic [CpWidth-1:0] cp,
                                            input len_type len_m1,
                                            input logic [1:0] idx);
      logic [7:0] r;
      r = Utf8Cont | {2'b00, cp[5:0]};
      unique case (len_m1)
         LEN_ONE: r = {1'b0, cp[6:0]};
         LEN_TWO: begin
            if (idx == 2'd0) r = Utf8Lead2 | {3'b000, cp[10:6]};
         end
         LEN_THREE: begin
            if (idx == 2'd0)      r = Utf8Lead3 | {4'h0, cp[15:12]};
            else if (idx == 2'd1) r = Utf8Cont | {2'b00, cp[11:6]};
         end
         LEN_FOUR: begin
            if (idx == 2'd0)      r = Utf8Lead4 | {5'h00, cp[20:18]};
            else if (idx == 2'd1) r = Utf8Cont | {2'b00, cp[17:12]};
            else if (idx == 2'd2) r = Utf8Cont | {2'b00, cp[11:6]};
         end
         default: r = Utf8Cont | {2'b00, cp[5:0]};
      endcase
      return r;
   endfunction

endpackage

[rtl/json_string_unescape_utf8.sv]
// Path: a code point is written into the command queue, and the encoder then loads
// its first byte into the output register, where it stays until it is taken.
// Throughput: one code point per cycle while the command queue has room; the encoder
// sends one UTF-8 byte per cycle while the output is taken, so a multi-byte character
// holds it until its bytes are sent; the four-entry queue absorbs the difference.
// Reset: synchronous, active high; clears decoder mode, queue and output valid.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string unescaper with UTF-8 byte output, split into a decoder front,
// a command queue and a byte encoder back.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [20:0] code_point, [23:21] zero
   input  logic        req_tlast,  // token_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,  // run_last
   output logic [2:0]  rsp_tuser   // [0] byte_valid, [1] token_end, [2] escape_error
);

   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;
   cmd_type q_cmd;
   cmd_type head_cmd;

   // Escape decoder.
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   // Command queue.
   jsu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Byte encoder.
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/jsu_fifo.sv]
// ----------------------------------------------------------------------------
// jsu_fifo
// Short command queue between the escape decoder and the byte encoder.
// ----------------------------------------------------------------------------
module jsu_fifo
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty,
   output logic    full
);

   cmd_type                 entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FifoCntWidth'(FifoDepth));
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: accepts one code point per cycle while the queue is not full and queues commands.
// ----------------------------------------------------------------------------
module jsu_front
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [20:0] code_point, [23:21] zero
   input  logic        req_tlast,  // token_last
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   mode_type           mode_ff, mode_in;
   logic [HexWidth-1:0] hex_ff, hex_in;
   logic [CpWidth-1:0] cp;
   logic               accept;
   logic               emit;
   logic               error;
   logic [CpWidth-1:0] value;
   hex_type            dig;
   esc_type            esc;
   logic [HexWidth-1:0] hex_shift;

   assign cp         = req_tdata[CpWidth-1:0];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign dig        = hex_digit(cp);
   assign esc        = escape_map(cp);
   assign hex_shift  = {hex_ff[HexWidth-5:0], dig.val};

   // Classification of the current character in the current mode.
   always_comb begin
      emit  = 1'b0;
      error = 1'b0;
      value = cp;
      unique case (mode_ff)
         MODE_PLAIN: begin
            emit = (cp != CharBackslash);
         end
         MODE_ESCAPE: begin
            value = {14'd0, esc.val};
            if (esc.ok) begin
               emit = 1'b1;
            end else if (cp != CharLowerU) begin
               error = 1'b1;
            end
         end
         MODE_HEX4, MODE_HEX3, MODE_HEX2, MODE_HEX1: begin
            value = {5'd0, hex_shift};
            error = !dig.ok;
            emit  = dig.ok && (mode_ff == MODE_HEX1);
         end
         MODE_DISCARD: begin
         end
         default: begin
         end
      endcase
   end

   // Next decoder state.
   always_comb begin
      mode_in = mode_ff;
      hex_in  = hex_ff;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (!emit) mode_in = MODE_ESCAPE;
         end
         MODE_ESCAPE: begin
            mode_in = MODE_PLAIN;
            if (!esc.ok && cp == CharLowerU) begin
               mode_in = MODE_HEX4;
               hex_in  = '0;
            end
         end
         MODE_HEX4: begin
            hex_in  = dig.ok ? hex_shift : hex_ff;
            mode_in = MODE_HEX3;
         end
         MODE_HEX3: begin
            hex_in  = dig.ok ? hex_shift : hex_ff;
            mode_in = MODE_HEX2;
         end
         MODE_HEX2: begin
            hex_in  = dig.ok ? hex_shift : hex_ff;
            mode_in = MODE_HEX1;
         end
         MODE_HEX1: begin
            hex_in  = dig.ok ? hex_shift : hex_ff;
            mode_in = MODE_PLAIN;
         end
         MODE_DISCARD: begin
         end
         default: mode_in = MODE_PLAIN;
      endcase
      if (error) mode_in = MODE_DISCARD;
      if (req_tlast) mode_in = MODE_PLAIN;
   end

   // Command for the back end; a token end with nothing else to say
   // closes cleanly only when the token was already being discarded.
   always_comb begin
      q_push        = accept && (emit || error || req_tlast);
      q_cmd.is_ctrl = !emit;
      q_cmd.err     = error || (!emit && mode_ff != MODE_DISCARD);
      q_cmd.last    = req_tlast;
      q_cmd.len_m1  = emit ? utf8_len(value) : LEN_ONE;
      q_cmd.value   = value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         hex_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_ff  <= hex_in;
      end
   end

endmodule

[rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Byte encoder: turns queued commands into UTF-8 byte results.
// ----------------------------------------------------------------------------
module jsu_back
   import jsu_pkg::*;
`include "json_string_unescape_utf8_assert.svh"
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic       rsp_tlast,  // run_last
   output logic [2:0] rsp_tuser   // [0] byte_valid, [1] token_end, [2] escape_error
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_tlast_ff, rsp_tlast_in;
   logic [2:0] rsp_user_ff, rsp_user_in;
   logic       load;
   logic       final_byte;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The output register takes a new byte when it is empty or being drained.
   assign load       = !q_empty && (!rsp_tvalid_ff || rsp_tready);
   assign final_byte = head_cmd.is_ctrl || (idx_ff == head_cmd.len_m1);
   assign q_pop      = load && final_byte;

   always_comb begin
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_user_in   = rsp_user_ff;
      if (load) begin
         idx_in        = final_byte ? 2'd0 : idx_ff + 2'd1;
         rsp_tvalid_in = 1'b1;
         rsp_byte_in   = head_cmd.is_ctrl ? 8'h00
                                          : utf8_byte(head_cmd.value, head_cmd.len_m1, idx_ff);
         rsp_tlast_in  = final_byte;
         rsp_user_in   = {head_cmd.is_ctrl && head_cmd.err,
                          final_byte && head_cmd.last,
                          !head_cmd.is_ctrl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Finishing a command always produces the run's last result.
   `JSU_ASSERT_NEXT(a_pop_gives_run_last, clock, reset, q_pop, rsp_tvalid_ff && rsp_tlast_ff)
   // A partly sent character stays at the head of the queue.
   `JSU_ASSERT_SAME(a_idx_has_entry, clock, reset, idx_ff != 2'd0, !q_empty && !head_cmd.is_ctrl && idx_ff <= head_cmd.len_m1)
   // An error result carries no byte and ends its run.
   `JSU_ASSERT_SAME(a_error_no_byte, clock, reset, rsp_tvalid_ff && rsp_user_ff[2], !rsp_user_ff[0] && rsp_byte_ff == 8'h00 && rsp_tlast_ff)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for json_string_unescape_utf8
// Feeds code points of JSON string tokens into the unescaper, with directed
// corner cases first and then random tokens (mostly well formed, some broken
// or cut short). A scoreboard decodes each accepted code point itself and
// checks every UTF-8 byte transaction field by field, in order. Both
// channels idle and stall at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 430;
   localparam int MaxIdle     = 11;
   localparam int DrainCycles = 16;
   localparam int CycleLimit  = 200000;

   // One expected byte transaction.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_last;
      logic       token_end;
      logic       error;
   } byte_result_type;

   // Scoreboard: decodes escapes, predicts UTF-8 bytes and checks results.
   class byte_scoreboard;
      mode_type        decode_mode;
      logic [15:0]     hex_acc;
      byte_result_type expected_bytes[$];
      int unsigned     mismatches;

      function new();
         decode_mode = MODE_PLAIN;
         hex_acc     = '0;
         mismatches  = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // Value of an ASCII hex digit, or -1 for any other character.
      function int hex_nibble(logic [CpWidth-1:0] cp);
         if (cp >= CharDigit0 && cp <= CharDigit9) return int'(cp - CharDigit0);
         if (cp >= CharLowerA && cp <= CharLowerF) return int'(cp - CharLowerA) + 10;
         if (cp >= CharUpperA && cp <= CharUpperF) return int'(cp - CharUpperA) + 10;
         return -1;
      endfunction

      // Advances the decoder by one accepted code point and queues its bytes.
      function void note_code_point(logic [CpWidth-1:0] cp, logic last);
         logic [7:0]         bytes[4];
         logic [CpWidth-1:0] value;
         logic               fault;
         logic               emit;
         logic               carries_byte;
         logic               flag_error;
         int                 count;
         int                 digit;
         byte_result_type    r;
         fault = 1'b0;
         emit  = 1'b0;
         value = '0;
         count = 0;
         carries_byte = 1'b1;
         flag_error   = 1'b0;
         foreach (bytes[k]) bytes[k] = 8'h00;

         case (decode_mode)
            MODE_PLAIN: begin
               if (cp == CharBackslash) begin
                  decode_mode = MODE_ESCAPE;
               end else begin
                  emit  = 1'b1;
                  value = cp;
               end
            end
            MODE_ESCAPE: begin
               decode_mode = MODE_PLAIN;
               emit = 1'b1;
               case (cp)
                  CharQuote, CharBackslash, CharSlash: value = cp;
                  CharLowerB: value = {14'b0, CtlBackspace};
                  CharLowerF: value = {14'b0, CtlFormFeed};
                  CharLowerN: value = {14'b0, CtlNewline};
                  CharLowerR: value = {14'b0, CtlReturn};
                  CharLowerT: value = {14'b0, CtlTab};
                  CharLowerU: begin
                     emit        = 1'b0;
                     hex_acc     = '0;
                     decode_mode = MODE_HEX4;
                  end
                  default: begin
                     emit  = 1'b0;
                     fault = 1'b1;
                  end
               endcase
            end
            MODE_HEX4, MODE_HEX3, MODE_HEX2, MODE_HEX1: begin
               digit = hex_nibble(cp);
               if (digit < 0) begin
                  fault = 1'b1;
               end else begin
                  hex_acc = {hex_acc[11:0], 4'(digit)};
                  case (decode_mode)
                     MODE_HEX4: decode_mode = MODE_HEX3;
                     MODE_HEX3: decode_mode = MODE_HEX2;
                     MODE_HEX2: decode_mode = MODE_HEX1;
                     default: begin
                        emit        = 1'b1;
                        value       = {5'b0, hex_acc};
                        decode_mode = MODE_PLAIN;
                     end
                  endcase
               end
            end
            default: ;
         endcase

         if (fault) begin
            // Bad escape or bad hex digit: one error transaction, then discard.
            count        = 1;
            carries_byte = 1'b0;
            flag_error   = 1'b1;
            decode_mode  = MODE_DISCARD;
         end else if (emit) begin
            if (value < 21'h80) begin
               count    = 1;
               bytes[0] = value[7:0];
            end else if (value < 21'h800) begin
               count    = 2;
               bytes[0] = Utf8Lead2 | {3'b000, value[10:6]};
               bytes[1] = Utf8Cont | {2'b00, value[5:0]};
            end else if (value < 21'h10000) begin
               count    = 3;
               bytes[0] = Utf8Lead3 | {4'h0, value[15:12]};
               bytes[1] = Utf8Cont | {2'b00, value[11:6]};
               bytes[2] = Utf8Cont | {2'b00, value[5:0]};
            end else begin
               count    = 4;
               bytes[0] = Utf8Lead4 | {5'h00, value[20:18]};
               bytes[1] = Utf8Cont | {2'b00, value[17:12]};
               bytes[2] = Utf8Cont | {2'b00, value[11:6]};
               bytes[3] = Utf8Cont | {2'b00, value[5:0]};
            end
         end else if (last) begin
            // Token closes with nothing to emit: a plain close after a discard,
            // an error when an escape is still open.
            count        = 1;
            carries_byte = 1'b0;
            flag_error   = (decode_mode != MODE_DISCARD);
         end

         for (int k = 0; k < count; k++) begin
            r.data      = bytes[k];
            r.valid     = carries_byte;
            r.run_last  = (k == count - 1);
            r.token_end = (k == count - 1) && last;
            r.error     = flag_error;
            expected_bytes.push_back(r);
         end
         if (last) decode_mode = MODE_PLAIN;
      endfunction

      task report(string what);
         mismatches++;
         $display("ERROR at %0t: %s", $realtime, what);
      endtask

      // Compares one accepted byte transaction with the oldest expectation.
      task check_byte(logic [7:0] data, logic run_last, logic [2:0] user);
         byte_result_type e;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h tlast %0b tuser %03b",
                             data, run_last, user));
            return;
         end
         e = expected_bytes.pop_front();
         if (data !== e.data)
            report($sformatf("out_byte %02h, expected %02h", data, e.data));
         if (user[0] !== e.valid)
            report($sformatf("byte_valid %0b, expected %0b", user[0], e.valid));
         if (run_last !== e.run_last)
            report($sformatf("run_last %0b, expected %0b", run_last, e.run_last));
         if (user[1] !== e.token_end)
            report($sformatf("token_end %0b, expected %0b", user[1], e.token_end));
         if (user[2] !== e.error)
            report($sformatf("escape_error %0b, expected %0b", user[2], e.error));
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // [20:0] code_point, [23:21] zero
   logic        req_tlast  = 1'b0; // token_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] out_byte
   logic        rsp_tlast;         // run_last
   logic [2:0]  rsp_tuser;         // [0] byte_valid, [1] token_end, [2] escape_error

   byte_scoreboard sb;
   int unsigned    cycle_count = 0;
   int unsigned    items_sent  = 0;
   bit             req_steady  = 1'b0;
   bit             rsp_steady  = 1'b0;

   json_string_unescape_utf8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 50 MHz clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("json_string_unescape_utf8: mismatch");
         $finish;
      end
   end

   // Sends one code point, after a random idle gap, and waits for the transaction.
   task automatic send_code_point(input logic [CpWidth-1:0] cp, input logic last);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, MaxIdle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cp};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_code_point(cp, last);
      items_sent++;
   endtask

   // ASCII hex digit for a nibble, letters in either case.
   function automatic logic [CpWidth-1:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return CharDigit0 + v;
      return ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + (v - 4'd10);
   endfunction

   function automatic logic [CpWidth-1:0] short_escape_letter();
      case ($urandom_range(0, 7))
         0: return CharQuote;
         1: return CharBackslash;
         2: return CharSlash;
         3: return CharLowerB;
         4: return CharLowerF;
         5: return CharLowerN;
         6: return CharLowerR;
         default: return CharLowerT;
      endcase
   endfunction

   // A plain character, mostly ASCII, never a backslash unless fully random.
   function automatic logic [CpWidth-1:0] plain_code_point();
      logic [CpWidth-1:0] cp;
      case ($urandom_range(0, 9))
         6: cp = CpWidth'($urandom_range(21'h80, 21'h7FF));
         7: cp = CpWidth'($urandom_range(21'h800, 21'hFFFF));
         8: cp = CpWidth'($urandom_range(21'h10000, 21'h10FFFF));
         9: cp = CpWidth'($urandom_range(0, 21'h10FFFF));
         default: begin
            cp = CpWidth'($urandom_range(0, 21'h7E));
            if (cp >= CharBackslash) cp = cp + 21'd1;
         end
      endcase
      return cp;
   endfunction

   // Builds and sends one random token: well formed most of the time, otherwise
   // with bad escapes, bad hex digits, stray backslashes or cut short.
   task automatic send_random_token();
      logic [CpWidth-1:0] body[$];
      logic [15:0]        hv;
      bit                 clean;
      int                 kind;
      int                 cut;
      clean = ($urandom_range(0, 9) < 8);
      repeat ($urandom_range(1, 8)) begin
         kind = clean ? $urandom_range(0, 9) : $urandom_range(0, 13);
         case (kind)
            6, 7: begin
               body.push_back(CharBackslash);
               body.push_back(short_escape_letter());
            end
            8, 9: begin
               case ($urandom_range(0, 2))
                  0: hv = 16'($urandom_range(0, 16'h7F));
                  1: hv = 16'($urandom_range(16'h80, 16'h7FF));
                  default: hv = 16'($urandom_range(0, 16'hFFFF));
               endcase
               body.push_back(CharBackslash);
               body.push_back(CharLowerU);
               for (int k = 3; k >= 0; k--) body.push_back(hex_char(hv[4*k +: 4]));
            end
            10: begin
               body.push_back(CharBackslash);
               body.push_back(CpWidth'($urandom_range(0, 21'h7F)));
            end
            11: begin
               body.push_back(CharBackslash);
               body.push_back(CharLowerU);
               repeat ($urandom_range(0, 3))
                  body.push_back(hex_char(4'($urandom_range(0, 15))));
               body.push_back(CpWidth'($urandom_range(0, 21'h7F)));
            end
            12: body.push_back(CpWidth'($urandom_range(0, 21'h10FFFF)));
            13: body.push_back(CharBackslash);
            default: body.push_back(plain_code_point());
         endcase
      end
      cut = body.size();
      if (!clean && $urandom_range(0, 1)) cut = $urandom_range(1, body.size());
      for (int k = 0; k < cut; k++) send_code_point(body[k], k == cut - 1);
   endtask

   // Byte channel: random stalls, then takes one transaction and checks it.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_steady = !rsp_steady;
         gap = rsp_steady ? 0 : $urandom_range(0, MaxIdle);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // Main sequence.
   initial begin
      int unsigned start;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Encoding length boundaries, top of the code space closing a token.
      send_code_point(21'h000000, 1'b0);
      send_code_point(21'h00007F, 1'b0);
      send_code_point(21'h000080, 1'b0);
      send_code_point(21'h0007FF, 1'b0);
      send_code_point(21'h000800, 1'b0);
      send_code_point(21'h00FFFF, 1'b0);
      send_code_point(21'h010000, 1'b0);
      send_code_point(21'h10FFFF, 1'b1);

      // Short escape, then a unicode escape with mixed-case hex digits.
      send_code_point(CharBackslash, 1'b0);
      send_code_point(CharLowerN, 1'b0);
      send_code_point(CharBackslash, 1'b0);
      send_code_point(CharLowerU, 1'b0);
      send_code_point(CharUpperF, 1'b0);
      send_code_point(CharLowerF, 1'b0);
      send_code_point(CharDigit0, 1'b0);
      send_code_point(CharDigit9, 1'b0);

      // Invalid escape letter; the rest of the token is discarded.
      send_code_point(CharBackslash, 1'b0);
      send_code_point(21'h000071, 1'b0);
      send_code_point(21'h000078, 1'b1);

      // Invalid hex digit, then discarded input closing the token.
      send_code_point(CharBackslash, 1'b0);
      send_code_point(CharLowerU, 1'b0);
      send_code_point(21'h000067, 1'b0);
      send_code_point(CharLowerA, 1'b1);

      // Escapes still open at the end of a token.
      send_code_point(CharBackslash, 1'b1);
      send_code_point(CharBackslash, 1'b0);
      send_code_point(CharLowerU, 1'b1);

      // Random tokens.
      start = items_sent;
      while (items_sent - start < RandomItems) begin
         if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
         send_random_token();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("json_string_unescape_utf8: match");
      end else begin
         $display("json_string_unescape_utf8: mismatch");
      end
      $finish;
   end

endmodule
